[hw/rtl/pcmsn_pkg.sv]
`default_nettype none
package pcmsn_pkg;

   // table geometry
   localparam int MAX_CHANNELS = 64;
   localparam int MAX_FRAME    = 4096;
   localparam int CH_W         = 6;
   localparam int ELEM_W       = 12;
   localparam int NCH_W        = 7;
   localparam int FRAME_W      = 13;
   localparam int DATA_W       = 32;
   localparam int CSR_IDX_W    = 2;

   // request function codes
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CHANNELS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_SIZE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE        = 2'd2;

   // divider: 50 quotient bits, two per cycle
   localparam int DVD_W     = 50;
   localparam int DIV_STEPS = 25;
   localparam int DIV_CNT_W = 5;

   // frame geometry seen by the front end
   typedef struct packed {
      logic [NCH_W-1:0]   num_channels;
      logic [FRAME_W-1:0] frame_size;
      logic               restart;
   } geometry_type;

   // one sample waiting between front and back
   typedef struct packed {
      logic [DATA_W-1:0] sample;
      logic [DATA_W-1:0] mean;
      logic [DATA_W-1:0] deviation;
      logic [CH_W-1:0]   channel;
      logic              last;
   } entry_type;

endpackage
`default_nettype wire

[hw/rtl/per_channel_mean_std_normalizer_unit.sv]
// Per-channel z-score normalizer for interleaved Q16.16 feature frames. A load request
// (func 0) writes one channel's mean and deviation into a 64-entry coefficient RAM; a sample
// request (func 1) is tagged with its channel and end-of-frame mark, picks up
// its coefficients from the RAM and waits in a two-entry queue for the arithmetic back end,
// which returns ((x - mean) / std) * scale truncated toward zero and saturated to 32 bits.
// The back end runs the radix-4 restoring divider for the 50-bit quotient, then two passes
// through one 32x32 multiplier, a sum and the saturation stage; a zero deviation skips the
// arithmetic and yields 0. The front end takes a load every cycle while no sample waits for
// its table read; a sample stalls all requests until the queue has room and takes it.
// Entries of the coefficient RAM read before being loaded give undefined results. Writing
// num_channels or frame_size restarts the frame; write registers only while idle.
`default_nettype none
module per_channel_mean_std_normalizer_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [pcmsn_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pcmsn_pkg::DATA_W-1:0]         csr_wr_data,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_func,
   input  wire logic [pcmsn_pkg::CH_W-1:0]           req_coef_channel,
   input  wire logic [pcmsn_pkg::DATA_W-1:0]         req_mean_value,
   input  wire logic [pcmsn_pkg::DATA_W-1:0]         req_std_value,
   input  wire logic [pcmsn_pkg::DATA_W-1:0]         req_sample_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [pcmsn_pkg::DATA_W-1:0]              rsp_out_value,
   output logic [pcmsn_pkg::CH_W-1:0]                rsp_out_channel,
   output logic                                      rsp_frame_last,
   output logic                                      rsp_saturated
);

   logic [pcmsn_pkg::NCH_W-1:0]   num_channels_ff, num_channels_in;
   logic [pcmsn_pkg::FRAME_W-1:0] frame_size_ff, frame_size_in;
   logic [pcmsn_pkg::DATA_W-1:0]  scale_ff, scale_in;
   pcmsn_pkg::geometry_type       geometry;
   logic                          push;
   pcmsn_pkg::entry_type          push_entry;
   logic                          queue_full;
   logic                          queue_empty;
   logic                          pop;
   pcmsn_pkg::entry_type          head;

   // configuration registers
   always_comb begin
      num_channels_in = num_channels_ff;
      frame_size_in   = frame_size_ff;
      scale_in        = scale_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pcmsn_pkg::CSR_NUM_CHANNELS: num_channels_in = csr_wr_data[pcmsn_pkg::NCH_W-1:0];
            pcmsn_pkg::CSR_FRAME_SIZE:   frame_size_in   = csr_wr_data[pcmsn_pkg::FRAME_W-1:0];
            pcmsn_pkg::CSR_SCALE:        scale_in        = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_channels_ff <= pcmsn_pkg::NCH_W'(1);
         frame_size_ff   <= pcmsn_pkg::FRAME_W'(1);
         scale_ff        <= pcmsn_pkg::DATA_W'(65536);
      end else begin
         num_channels_ff <= num_channels_in;
         frame_size_ff   <= frame_size_in;
         scale_ff        <= scale_in;
      end
   end

   // geometry change restarts the frame
   always_comb begin
      geometry.num_channels = num_channels_ff;
      geometry.frame_size   = frame_size_ff;
      geometry.restart      = csr_wr_en && ((csr_index == pcmsn_pkg::CSR_NUM_CHANNELS) ||
                                            (csr_index == pcmsn_pkg::CSR_FRAME_SIZE));
   end

   pcmsn_front u_front (
      .clock            (clock),
      .reset            (reset),
      .geometry         (geometry),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_coef_channel (req_coef_channel),
      .req_mean_value   (req_mean_value),
      .req_std_value    (req_std_value),
      .req_sample_value (req_sample_value),
      .push             (push),
      .push_entry       (push_entry),
      .queue_full       (queue_full)
   );

   pcmsn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_entry  (head),
      .empty      (queue_empty)
   );

   pcmsn_back u_back (
      .clock           (clock),
      .reset           (reset),
      .scale           (scale_ff),
      .queue_empty     (queue_empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_channel (rsp_out_channel),
      .rsp_frame_last  (rsp_frame_last),
      .rsp_saturated   (rsp_saturated)
   );

endmodule
`default_nettype wire

[hw/rtl/pcmsn_ram.sv]
`default_nettype none
module pcmsn_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/pcmsn_front.sv]
`default_nettype none
module pcmsn_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pcmsn_pkg::geometry_type             geometry,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_func,
   input  wire logic [pcmsn_pkg::CH_W-1:0]          req_coef_channel,
   input  wire logic [pcmsn_pkg::DATA_W-1:0]        req_mean_value,
   input  wire logic [pcmsn_pkg::DATA_W-1:0]        req_std_value,
   input  wire logic [pcmsn_pkg::DATA_W-1:0]        req_sample_value,
   output logic                                     push,
   output pcmsn_pkg::entry_type                     push_entry,
   input  wire logic                                queue_full
);

   logic                                  accept;
   logic                                  load_accept;
   logic                                  sample_accept;
   logic [pcmsn_pkg::NCH_W-1:0]           nc_eff;
   logic [pcmsn_pkg::FRAME_W-1:0]         fs_eff;
   logic [pcmsn_pkg::CH_W-1:0]            ch;
   logic                                  last;
   logic [pcmsn_pkg::NCH_W-1:0]           ch_plus;
   logic [pcmsn_pkg::FRAME_W-1:0]         elem_plus;
   logic [2*pcmsn_pkg::DATA_W-1:0]        rd_data;

   logic                                  pending_ff, pending_in;
   logic [pcmsn_pkg::CH_W-1:0]            channel_ff, channel_in;
   logic [pcmsn_pkg::ELEM_W-1:0]          element_ff, element_in;
   logic [pcmsn_pkg::DATA_W-1:0]          sample_ff, sample_in;
   logic [pcmsn_pkg::CH_W-1:0]            meta_ch_ff, meta_ch_in;
   logic                                  meta_last_ff, meta_last_in;

   // one sample at a time waits for its table read
   assign req_stall     = pending_ff;
   assign accept        = req_valid && !req_stall;
   assign load_accept   = accept && (req_func == pcmsn_pkg::FUNC_LOAD);
   assign sample_accept = accept && (req_func == pcmsn_pkg::FUNC_SAMPLE);

   // clamp geometry to the supported range
   always_comb begin
      if (geometry.num_channels == '0) begin
         nc_eff = pcmsn_pkg::NCH_W'(1);
      end else if (geometry.num_channels > pcmsn_pkg::NCH_W'(pcmsn_pkg::MAX_CHANNELS)) begin
         nc_eff = pcmsn_pkg::NCH_W'(pcmsn_pkg::MAX_CHANNELS);
      end else begin
         nc_eff = geometry.num_channels;
      end
      if (geometry.frame_size == '0) begin
         fs_eff = pcmsn_pkg::FRAME_W'(1);
      end else if (geometry.frame_size > pcmsn_pkg::FRAME_W'(pcmsn_pkg::MAX_FRAME)) begin
         fs_eff = pcmsn_pkg::FRAME_W'(pcmsn_pkg::MAX_FRAME);
      end else begin
         fs_eff = geometry.frame_size;
      end
   end

   // channel and end-of-frame for the sample at the port
   assign ch        = ({1'b0, channel_ff} < nc_eff) ? channel_ff : '0;
   assign ch_plus   = {1'b0, ch} + pcmsn_pkg::NCH_W'(1);
   assign elem_plus = {1'b0, element_ff} + pcmsn_pkg::FRAME_W'(1);
   assign last      = (elem_plus >= fs_eff);

   // coefficient table: mean in the upper half, deviation in the lower
   pcmsn_ram #(
      .WIDTH (2 * pcmsn_pkg::DATA_W),
      .DEPTH (pcmsn_pkg::MAX_CHANNELS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (load_accept),
      .wr_addr (req_coef_channel),
      .wr_data ({req_mean_value, req_std_value}),
      .rd_en   (sample_accept),
      .rd_addr (ch),
      .rd_data (rd_data)
   );

   // hand the sample to the queue once the table data is back
   assign push = pending_ff && !queue_full;
   always_comb begin
      push_entry.sample    = sample_ff;
      push_entry.mean      = rd_data[2*pcmsn_pkg::DATA_W-1:pcmsn_pkg::DATA_W];
      push_entry.deviation = rd_data[pcmsn_pkg::DATA_W-1:0];
      push_entry.channel   = meta_ch_ff;
      push_entry.last      = meta_last_ff;
   end

   // counters and pending stage
   always_comb begin
      pending_in   = pending_ff;
      channel_in   = channel_ff;
      element_in   = element_ff;
      sample_in    = sample_ff;
      meta_ch_in   = meta_ch_ff;
      meta_last_in = meta_last_ff;
      if (push) begin
         pending_in = 1'b0;
      end
      if (sample_accept) begin
         pending_in   = 1'b1;
         sample_in    = req_sample_value;
         meta_ch_in   = ch;
         meta_last_in = last;
         if (last) begin
            channel_in = '0;
            element_in = '0;
         end else begin
            element_in = elem_plus[pcmsn_pkg::ELEM_W-1:0];
            channel_in = (ch_plus >= nc_eff) ? '0 : ch_plus[pcmsn_pkg::CH_W-1:0];
         end
      end
      if (geometry.restart) begin
         channel_in = '0;
         element_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         channel_ff <= '0;
         element_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         channel_ff <= channel_in;
         element_ff <= element_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      meta_ch_ff   <= meta_ch_in;
      meta_last_ff <= meta_last_in;
   end

endmodule
`default_nettype wire

[hw/rtl/pcmsn_queue.sv]
`default_nettype none
module pcmsn_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire pcmsn_pkg::entry_type push_entry,
   output logic                      full,
   input  wire logic                 pop,
   output pcmsn_pkg::entry_type      pop_entry,
   output logic                      empty
);

   localparam int DEPTH = 2;
   localparam int PTR_W = 1;

   pcmsn_pkg::entry_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]        count_ff, count_in;

   assign full      = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/pcmsn_back.sv]
`default_nettype none
module pcmsn_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [pcmsn_pkg::DATA_W-1:0] scale,
   input  wire logic                         queue_empty,
   input  wire pcmsn_pkg::entry_type         head,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [pcmsn_pkg::DATA_W-1:0]      rsp_out_value,
   output logic [pcmsn_pkg::CH_W-1:0]        rsp_out_channel,
   output logic                              rsp_frame_last,
   output logic                              rsp_saturated
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_MUL_HI = 3'd2;
   localparam logic [2:0] ST_MUL_LO = 3'd3;
   localparam logic [2:0] ST_SUM    = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   localparam int W  = pcmsn_pkg::DATA_W;
   localparam int DW = pcmsn_pkg::DVD_W;

   // one restoring step: next remainder, shifted dividend with quotient bit
   function automatic logic [W+DW-1:0] div_step(input logic [W-1:0]  rem,
                                                input logic [DW-1:0] dvd,
                                                input logic [W-1:0]  dvsr);
      logic [W:0]   trial;
      logic [W:0]   sub;
      logic         q_bit;
      logic [W-1:0] rem_n;
      trial = {rem, dvd[DW-1]};
      sub   = trial - {1'b0, dvsr};
      q_bit = (trial >= {1'b0, dvsr});
      rem_n = q_bit ? sub[W-1:0] : trial[W-1:0];
      return {rem_n, dvd[DW-2:0], q_bit};
   endfunction

   logic [2:0]                      state_ff, state_in;
   logic [pcmsn_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]                    rem_ff, rem_in;
   logic [DW-1:0]                   dvd_ff, dvd_in;
   logic [W-1:0]                    dvsr_ff, dvsr_in;
   logic                            neg_ff, neg_in;
   logic [pcmsn_pkg::CH_W-1:0]      ch_ff, ch_in;
   logic                            last_ff, last_in;
   logic [2*W-1:0]                  p_hi_ff, p_hi_in;
   logic [W-1:0]                    p_lo_ff, p_lo_in;
   logic [2*W-1:0]                  mag_ff, mag_in;

   logic                            out_valid_ff, out_valid_in;
   logic [W-1:0]                    out_value_ff, out_value_in;
   logic [pcmsn_pkg::CH_W-1:0]      out_ch_ff, out_ch_in;
   logic                            out_last_ff, out_last_in;
   logic                            out_sat_ff, out_sat_in;

   logic [W:0]                      diff;
   logic [W:0]                      diff_mag;
   logic [W-1:0]                    dev_mag;
   logic [W-1:0]                    scale_mag;
   logic [W+DW-1:0]                 step_a;
   logic [W+DW-1:0]                 step_b;
   logic [W-1:0]                    mul_a;
   logic [2*W-1:0]                  prod;
   logic                            over;
   logic [2*W-1:0]                  limit;
   logic                            sat;
   logic [2*W-1:0]                  mag_clip;
   logic [2*W-1:0]                  mag_signed;
   logic                            out_free;

   // operand magnitudes at the queue head
   assign diff      = {head.sample[W-1], head.sample} - {head.mean[W-1], head.mean};
   assign diff_mag  = diff[W] ? ((W+1)'(0) - diff) : diff;
   assign dev_mag   = head.deviation[W-1] ? (W'(0) - head.deviation) : head.deviation;
   assign scale_mag = scale[W-1] ? (W'(0) - scale) : scale;

   // two quotient bits per cycle
   assign step_a = div_step(rem_ff, dvd_ff, dvsr_ff);
   assign step_b = div_step(step_a[W+DW-1:DW], step_a[DW-1:0], dvsr_ff);

   // shared multiplier: integer part first, then fraction
   assign mul_a = (state_ff == ST_MUL_HI) ? dvd_ff[W+15:16] : {16'b0, dvd_ff[15:0]};
   assign prod  = {{W{1'b0}}, mul_a} * {{W{1'b0}}, scale_mag};

   // saturation and sign
   assign over       = dvd_ff[W+16];
   assign limit      = neg_ff ? (2*W)'(64'h8000_0000) : (2*W)'(64'h7FFF_FFFF);
   assign sat        = over || (mag_ff > limit);
   assign mag_clip   = sat ? limit : mag_ff;
   assign mag_signed = neg_ff ? ((2*W)'(0) - mag_clip) : mag_clip;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign pop      = (state_ff == ST_IDLE) && !queue_empty;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      dvsr_in      = dvsr_ff;
      neg_in       = neg_ff;
      ch_in        = ch_ff;
      last_in      = last_ff;
      p_hi_in      = p_hi_ff;
      p_lo_in      = p_lo_ff;
      mag_in       = mag_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_value_in = out_value_ff;
      out_ch_in    = out_ch_ff;
      out_last_in  = out_last_ff;
      out_sat_in   = out_sat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               ch_in   = head.channel;
               last_in = head.last;
               neg_in  = (diff[W] != head.deviation[W-1]) != scale[W-1];
               rem_in  = '0;
               dvd_in  = {1'b0, diff_mag, 16'b0};
               dvsr_in = dev_mag;
               cnt_in  = '0;
               if (head.deviation == '0) begin
                  // zero deviation gives zero
                  dvd_in   = '0;
                  mag_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in = step_b[W+DW-1:DW];
            dvd_in = step_b[DW-1:0];
            cnt_in = cnt_ff + pcmsn_pkg::DIV_CNT_W'(1);
            if (cnt_ff == pcmsn_pkg::DIV_CNT_W'(pcmsn_pkg::DIV_STEPS - 1)) begin
               state_in = ST_MUL_HI;
            end
         end
         ST_MUL_HI: begin
            p_hi_in  = prod;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            p_lo_in  = prod[W+15:16];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            mag_in   = p_hi_ff + {{W{1'b0}}, p_lo_ff};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = mag_signed[W-1:0];
               out_ch_in    = ch_ff;
               out_last_in  = last_ff;
               out_sat_in   = sat;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      dvsr_ff      <= dvsr_in;
      neg_ff       <= neg_in;
      ch_ff        <= ch_in;
      last_ff      <= last_in;
      p_hi_ff      <= p_hi_in;
      p_lo_ff      <= p_lo_in;
      mag_ff       <= mag_in;
      out_value_ff <= out_value_in;
      out_ch_ff    <= out_ch_in;
      out_last_ff  <= out_last_in;
      out_sat_ff   <= out_sat_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_value   = out_value_ff;
   assign rsp_out_channel = out_ch_ff;
   assign rsp_frame_last  = out_last_ff;
   assign rsp_saturated   = out_sat_ff;

endmodule
`default_nettype wire

[bench/tb_per_channel_mean_std_normalizer_unit.sv]
`timescale 1ns / 1ps

// one normalized element as it leaves the block
typedef struct packed {
   logic [pcmsn_pkg::DATA_W-1:0] value;
   logic [pcmsn_pkg::CH_W-1:0]   channel;
   logic                         last;
   logic                         sat;
} norm_result_type;

// mirrors coefficient tables, counters and registers; holds the results still owed
class norm_scoreboard;
   logic [pcmsn_pkg::DATA_W-1:0]  mean_tab [pcmsn_pkg::MAX_CHANNELS];
   logic [pcmsn_pkg::DATA_W-1:0]  dev_tab  [pcmsn_pkg::MAX_CHANNELS];
   logic [pcmsn_pkg::NCH_W-1:0]   num_channels;
   logic [pcmsn_pkg::FRAME_W-1:0] frame_size;
   logic [pcmsn_pkg::DATA_W-1:0]  scale;
   logic [pcmsn_pkg::CH_W-1:0]    channel_cnt;
   logic [pcmsn_pkg::ELEM_W-1:0]  element_cnt;
   norm_result_type               owed_q [$];
   int                            errors;

   function new();
      num_channels = 1;
      frame_size   = 1;
      scale        = 32'h0001_0000;
      channel_cnt  = '0;
      element_cnt  = '0;
      errors       = 0;
   endfunction

   function int pending();
      return owed_q.size();
   endfunction

   function int eff_channels();
      if (num_channels == 0) return 1;
      if (num_channels > pcmsn_pkg::MAX_CHANNELS) return pcmsn_pkg::MAX_CHANNELS;
      return num_channels;
   endfunction

   function int eff_frame();
      if (frame_size == 0) return 1;
      if (frame_size > pcmsn_pkg::MAX_FRAME) return pcmsn_pkg::MAX_FRAME;
      return frame_size;
   endfunction

   // channel the next sample request will be tagged with
   function logic [pcmsn_pkg::CH_W-1:0] next_channel();
      return (int'(channel_cnt) < eff_channels()) ? channel_cnt : '0;
   endfunction

   // geometry writes restart the frame, a scale write does not
   function void write_register(logic [pcmsn_pkg::CSR_IDX_W-1:0] idx,
                                logic [pcmsn_pkg::DATA_W-1:0] data);
      case (idx)
         pcmsn_pkg::CSR_NUM_CHANNELS: begin
            num_channels = data[pcmsn_pkg::NCH_W-1:0];
            channel_cnt  = '0;
            element_cnt  = '0;
         end
         pcmsn_pkg::CSR_FRAME_SIZE: begin
            frame_size  = data[pcmsn_pkg::FRAME_W-1:0];
            channel_cnt = '0;
            element_cnt = '0;
         end
         pcmsn_pkg::CSR_SCALE: scale = data;
         default: ;
      endcase
   endfunction

   // ((x - mean) / std) * scale, truncated toward zero, saturated to 32 bits
   function logic [pcmsn_pkg::DATA_W-1:0] z_score(logic [pcmsn_pkg::CH_W-1:0] ch,
                                                  logic [pcmsn_pkg::DATA_W-1:0] sample,
                                                  output logic sat);
      longint      x, m, d, g, diff;
      logic [63:0] q, sm, mag, lim, diff_mag, dev_mag;
      logic        neg, over;
      sat  = 1'b0;
      over = 1'b0;
      x = $signed(sample);
      m = $signed(mean_tab[ch]);
      d = $signed(dev_tab[ch]);
      g = $signed(scale);
      if (d == 0) return '0;
      diff     = x - m;
      neg      = (diff < 0) != (d < 0);
      diff_mag = (diff < 0) ? -diff : diff;
      dev_mag  = (d < 0) ? -d : d;
      q        = (diff_mag << 16) / dev_mag;
      sm       = (g < 0) ? -g : g;
      if (g < 0) neg = !neg;
      if (q == 0 || sm == 0) begin
         mag = '0;
      end else if ((q >> 16) >= 64'h1_0000_0000) begin
         over = 1'b1;
         mag  = '0;
      end else begin
         mag = (q >> 16) * sm + (((q & 64'hFFFF) * sm) >> 16);
      end
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (over || mag > lim) begin
         sat = 1'b1;
         mag = lim;
      end
      if (neg) mag = -mag;
      return mag[pcmsn_pkg::DATA_W-1:0];
   endfunction

   // accepted request: loads fill the tables, samples owe one result
   function void note_request(logic func, logic [pcmsn_pkg::CH_W-1:0] coef_ch,
                              logic [pcmsn_pkg::DATA_W-1:0] mean,
                              logic [pcmsn_pkg::DATA_W-1:0] dev,
                              logic [pcmsn_pkg::DATA_W-1:0] sample);
      norm_result_type             r;
      logic                        sat_flag;
      logic [pcmsn_pkg::CH_W-1:0]  ch;
      int                          nc;
      if (func == pcmsn_pkg::FUNC_LOAD) begin
         mean_tab[coef_ch] = mean;
         dev_tab[coef_ch]  = dev;
         return;
      end
      nc        = eff_channels();
      ch        = next_channel();
      r.channel = ch;
      r.last    = (int'(element_cnt) + 1 >= eff_frame());
      r.value   = z_score(ch, sample, sat_flag);
      r.sat     = sat_flag;
      owed_q.push_back(r);
      if (r.last) begin
         element_cnt = '0;
         channel_cnt = '0;
      end else begin
         element_cnt = element_cnt + 1'b1;
         channel_cnt = (int'(ch) + 1 >= nc) ? '0 : ch + 1'b1;
      end
   endfunction

   task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // compare an accepted result with the oldest one owed
   task check_result(norm_result_type got);
      norm_result_type want;
      if (owed_q.size() == 0) begin
         report($sformatf("unexpected result value %h channel %0d", got.value, got.channel));
         return;
      end
      want = owed_q.pop_front();
      if (got.value !== want.value)
         report($sformatf("out_value %h, wanted %h", got.value, want.value));
      if (got.channel !== want.channel)
         report($sformatf("out_channel %0d, wanted %0d", got.channel, want.channel));
      if (got.last !== want.last)
         report($sformatf("frame_last %b, wanted %b", got.last, want.last));
      if (got.sat !== want.sat)
         report($sformatf("saturated %b, wanted %b", got.sat, want.sat));
   endtask
endclass

module tb_per_channel_mean_std_normalizer_unit;

   localparam logic [pcmsn_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 200;
   localparam int SETTLE      = 40;
   localparam int STUCK_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                csr_wr_en;
   logic [pcmsn_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [pcmsn_pkg::DATA_W-1:0]        csr_wr_data;
   logic                                req_valid;
   logic                                req_stall;
   logic                                req_func;
   logic [pcmsn_pkg::CH_W-1:0]          req_coef_channel;
   logic [pcmsn_pkg::DATA_W-1:0]        req_mean_value;
   logic [pcmsn_pkg::DATA_W-1:0]        req_std_value;
   logic [pcmsn_pkg::DATA_W-1:0]        req_sample_value;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [pcmsn_pkg::DATA_W-1:0]        rsp_out_value;
   logic [pcmsn_pkg::CH_W-1:0]          rsp_out_channel;
   logic                                rsp_frame_last;
   logic                                rsp_saturated;

   norm_scoreboard sb = new();
   bit             loaded [pcmsn_pkg::MAX_CHANNELS];
   int             send_idle_pct;
   int             recv_idle_pct;
   int             hold_req;
   int             hold_seen;
   int             hold_left;
   int             stuck_cycles;

   // geometry and gain of each random phase
   int          phase_nc [PHASES] = '{1, 3, 64, 0, 127, 8, 65, 16, 4};
   int          phase_fs [PHASES] = '{1, 10, 4096, 0, 8191, 64, 4097, 48, 4};
   logic [31:0] phase_gain [PHASES] = '{32'h0001_0000, 32'h0002_0000, 32'h7FFF_FFFF,
                                        32'h8000_0000, 32'h0000_0000, 32'hFFFF_0000,
                                        32'h0000_0001, 32'h0003_4000, 32'h0001_0000};

   per_channel_mean_std_normalizer_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_coef_channel (req_coef_channel),
      .req_mean_value   (req_mean_value),
      .req_std_value    (req_std_value),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_saturated    (rsp_saturated)
   );

   always #5 clock = ~clock;

   // receiver: random stall, or a long hold-off once one is asked for
   always @(negedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // result check and stuck-run watchdog
   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_result('{rsp_out_value, rsp_out_channel, rsp_frame_last, rsp_saturated});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   function automatic logic [31:0] extreme_word();
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return 32'h0000_0001;
      endcase
   endfunction

   // Q16.16 operand: mostly within +-16, some full range and extremes
   function automatic logic [31:0] rand_q();
      case ($urandom_range(7))
         0: return extreme_word();
         1, 2: return $urandom;
         default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   // deviation: zero now and then, mostly small of either sign
   function automatic logic [31:0] rand_dev();
      logic [31:0] v;
      case ($urandom_range(9))
         0: return '0;
         1: return extreme_word();
         2: return $urandom;
         default: begin
            v = $urandom_range(32'h0008_0000, 1);
            return $urandom_range(1) ? -v : v;
         end
      endcase
   endfunction

   // hold the request until accepted, then note it
   task automatic offer_request(logic func, logic [pcmsn_pkg::CH_W-1:0] ch,
                                logic [pcmsn_pkg::DATA_W-1:0] mean,
                                logic [pcmsn_pkg::DATA_W-1:0] dev,
                                logic [pcmsn_pkg::DATA_W-1:0] sample);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_coef_channel <= ch;
      req_mean_value   <= mean;
      req_std_value    <= dev;
      req_sample_value <= sample;
      do @(posedge clock); while (req_stall);
      sb.note_request(func, ch, mean, dev, sample);
   endtask

   task automatic load_channel(logic [pcmsn_pkg::CH_W-1:0] ch,
                               logic [pcmsn_pkg::DATA_W-1:0] mean,
                               logic [pcmsn_pkg::DATA_W-1:0] dev);
      offer_request(pcmsn_pkg::FUNC_LOAD, ch, mean, dev, $urandom);
      loaded[ch] = 1'b1;
   endtask

   // sample request; its channel gets coefficients first if it has none yet
   task automatic normalize_sample(logic [pcmsn_pkg::DATA_W-1:0] x);
      logic [pcmsn_pkg::CH_W-1:0] ch;
      ch = sb.next_channel();
      if (!loaded[ch]) load_channel(ch, rand_q(), rand_dev());
      offer_request(pcmsn_pkg::FUNC_SAMPLE, pcmsn_pkg::CH_W'($urandom), $urandom, $urandom,
                    x);
   endtask

   task automatic write_register(logic [pcmsn_pkg::CSR_IDX_W-1:0] idx,
                                 logic [pcmsn_pkg::DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      sb.write_register(idx, data);
   endtask

   // stop offering and let every owed result come back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wr_data      = '0;
      req_valid        = 1'b0;
      req_func         = pcmsn_pkg::FUNC_LOAD;
      req_coef_channel = '0;
      req_mean_value   = '0;
      req_std_value    = '0;
      req_sample_value = '0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset geometry, unit deviation and field extremes
      load_channel(6'd0, 32'h0000_0000, 32'h0001_0000);
      normalize_sample(32'h7FFF_FFFF);
      normalize_sample(32'h8000_0000);
      normalize_sample(32'h0001_8000);
      normalize_sample(32'h0000_0000);
      // zero deviation gives zero
      load_channel(6'd0, 32'h0001_0000, 32'h0000_0000);
      normalize_sample(32'h1234_5678);
      // one-lsb deviation overflows the quotient
      load_channel(6'd0, 32'h8000_0000, 32'h0000_0001);
      normalize_sample(32'h7FFF_FFFF);
      // most negative deviation, widest difference
      load_channel(6'd0, 32'h7FFF_FFFF, 32'h8000_0000);
      normalize_sample(32'h8000_0000);
      // negative deviation of one lsb clips positive
      load_channel(6'd0, 32'h0000_0000, 32'hFFFF_FFFF);
      normalize_sample(32'hFFFF_0000);
      // negative difference just short of -1 over a deviation of one half
      load_channel(6'd0, 32'h0001_0000, 32'h0000_8000);
      normalize_sample(32'h0000_0001);
      load_channel(6'd63, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      wait_for_results();

      // random phases across geometry, gain and idling
      for (int p = 0; p < PHASES; p++) begin
         case (p / 3)
            0: begin send_idle_pct = 29; recv_idle_pct = 79; end
            1: begin send_idle_pct = 79; recv_idle_pct = 29; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (p == 0) write_register(CSR_UNUSED, $urandom);
         write_register(pcmsn_pkg::CSR_NUM_CHANNELS, phase_nc[p]);
         write_register(pcmsn_pkg::CSR_FRAME_SIZE, phase_fs[p]);
         write_register(pcmsn_pkg::CSR_SCALE, (p == 7) ? $urandom : phase_gain[p]);
         @(negedge clock);
         csr_wr_en <= 1'b0;

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // receiver holds off while requests keep coming
            if (p == 6 && k == 40) hold_req++;
            // sender pauses until everything owed has come back
            if (p == 6 && k == 140) begin
               @(negedge clock);
               req_valid <= 1'b0;
               while (sb.pending() != 0) @(posedge clock);
            end
            if ($urandom_range(99) < 12)
               load_channel(pcmsn_pkg::CH_W'($urandom_range(pcmsn_pkg::MAX_CHANNELS - 1)),
                            rand_q(), rand_dev());
            else
               normalize_sample(rand_q());
         end
         wait_for_results();
      end

      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
